>>> design/ecv_pkg.sv
// shared constants, codes and curve tables for the easing curve evaluator
// no dependencies; imported by the core, its checker and the testbench
package ecv_pkg;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int EXP_TABLE_DEPTH  = 1024;
    localparam int SINE_BITS        = $clog2(SINE_TABLE_DEPTH);
    localparam int EXP_BITS         = $clog2(EXP_TABLE_DEPTH);

    // curve selector codes
    localparam logic [4:0] FUNC_LINEAR = 5'd0;
    localparam logic [4:0] FUNC_LAST   = 5'd16;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] HALF_Q16    = 17'd32768;
    localparam logic [18:0] BACK_S1     = 19'd177051;
    localparam logic [16:0] BACK_S      = 17'd111515;
    localparam logic [22:0] DIV3_RECIP  = 23'd5592406;
    localparam logic [20:0] PHASE_OFS   = 21'd737281;

    localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam longint      ONE_Q30     = 64'sd1073741824;

    typedef enum logic [4:0] {
        K_LIN     = 5'b00001,
        K_CUBIC   = 5'b00010,
        K_BACK    = 5'b00100,
        K_ELASTIC = 5'b01000,
        K_BOUNCE  = 5'b10000
    } t_kind;

    typedef enum logic [2:0] {
        POST_NONE    = 3'b001,
        POST_HALF    = 3'b010,
        POST_HALF_UP = 3'b100
    } t_post;

    typedef struct packed {
        t_kind kind;
        logic  is_out;
        t_post post;
        logic  ep;
    } t_ctl;

    typedef logic signed [17:0] t_sine_rom [SINE_TABLE_DEPTH];
    typedef logic [30:0]        t_exp_rom  [EXP_TABLE_DEPTH];

    // truncating signed divide for the table builders, shift and subtract
    function automatic longint f_div_trunc(longint a, longint d);
        logic [63:0] ua;
        logic [63:0] ud;
        logic [63:0] q;
        logic [63:0] rem;
        logic        neg;
        int          b;
        neg = (a < 0) != (d < 0);
        ua  = (a < 0) ? 64'(-a) : 64'(a);
        ud  = (d < 0) ? 64'(-d) : 64'(d);
        q   = '0;
        rem = '0;
        for (b = 63; b >= 0; b--) begin
            rem = {rem[62:0], ua[b]};
            if (rem >= ud) begin
                rem  = rem - ud;
                q[b] = 1'b1;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // one turn of sine, q16, taylor series on the quarter-wave angle
    function automatic t_sine_rom f_sine_rom();
        t_sine_rom   rom;
        logic [63:0] f;
        logic [63:0] x;
        longint      xs;
        longint      term;
        longint      sum;
        logic        neg;
        int          i;
        int          k;
        for (i = 0; i < SINE_TABLE_DEPTH; i++) begin
            f   = (64'(i) << 32) / SINE_TABLE_DEPTH;
            neg = 1'b0;
            if (f >= 64'h8000_0000) begin
                neg = 1'b1;
                f   = f - 64'h8000_0000;
            end
            if (f > 64'h4000_0000) begin
                f = 64'h8000_0000 - f;
            end
            x    = (f * TWO_PI_Q30) >> 32;
            xs   = longint'(x);
            term = xs;
            sum  = xs;
            for (k = 1; k <= 6; k++) begin
                term = (term * xs) / ONE_Q30;
                term = (term * xs) / ONE_Q30;
                term = f_div_trunc(-term, longint'((2 * k) * (2 * k + 1)));
                sum  = sum + term;
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum    = (sum + 8192) >>> 14;
            rom[i] = neg ? 18'(-sum) : 18'(sum);
        end
        return rom;
    endfunction

    // 2^(-j/depth) in q30
    function automatic t_exp_rom f_exp_rom();
        t_exp_rom    rom;
        logic [63:0] x;
        logic [63:0] y;
        longint      ys;
        longint      term;
        longint      sum;
        int          j;
        int          k;
        for (j = 0; j < EXP_TABLE_DEPTH; j++) begin
            x    = (64'(j) << 32) / EXP_TABLE_DEPTH;
            y    = (x * LN2_Q30) >> 32;
            ys   = longint'(y);
            term = ONE_Q30;
            sum  = ONE_Q30;
            for (k = 1; k <= 12; k++) begin
                term = f_div_trunc(-((term * ys) / ONE_Q30), longint'(k));
                sum  = sum + term;
            end
            rom[j] = 31'(sum);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_sine_rom();
    localparam t_exp_rom  EXP_ROM  = f_exp_rom();

endpackage

>>> design/easing_curve_evaluator_core.sv
// easing curve evaluator: seven-stage pipeline from selector and ratio to eased value
// depends on ecv_pkg for codes, constants and the sine and exp2 tables
//
// One word is taken on every clock edge where start is high (busy is always low, the
// pipeline never stalls) and its eased value appears on o_eased_value with o_valid high
// for exactly one cycle. A word may follow in every cycle, so the throughput is one word
// per clock; the datapath has seven register stages (operand set-up, first products,
// table reads and second products, cubic and bounce results, back result, elastic
// result, halving and saturation). The receiver has no way to hold results off and must
// take each one as it comes. Ratios above 1.0 are treated as 1.0, unused selectors
// behave as linear, and the result is saturated to the signed 18-bit range.
module easing_curve_evaluator_core
    import ecv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [4:0]         i_func,
    input  logic [16:0]        i_ratio,
    output logic               o_valid,
    output logic signed [17:0] o_eased_value
);

    typedef struct packed {
        t_ctl               ctl;
        logic signed [17:0] s;
        logic signed [19:0] b;
    } t_st1;

    typedef struct packed {
        t_ctl                ctl;
        logic signed [17:0]  s;
        logic signed [19:0]  b;
        logic [32:0]         sq;
        logic signed [36:0]  m;
        logic [EXP_BITS-1:0] ej;
        logic [3:0]          eip;
        logic [43:0]         phm;
        logic signed [19:0]  u;
        logic [15:0]         badd;
    } t_st2;

    typedef struct packed {
        t_ctl               ctl;
        logic signed [19:0] b;
        logic signed [51:0] c3;
        logic [16:0]        t2;
        logic signed [19:0] inner;
        logic signed [17:0] sn;
        logic [30:0]        ex;
        logic [3:0]         eip;
        logic [36:0]        uu;
        logic [15:0]        badd;
    } t_st3;

    typedef struct packed {
        t_ctl               ctl;
        logic signed [19:0] b;
        logic signed [37:0] bp;
        logic [16:0]        pw;
        logic signed [17:0] sn;
    } t_st4;

    typedef struct packed {
        t_ctl               ctl;
        logic signed [19:0] b;
        logic signed [35:0] q;
    } t_st5;

    typedef struct packed {
        t_ctl               ctl;
        logic signed [19:0] b;
    } t_st6;

    // valid bits, one per stage, stage 7 is the output register
    logic [6:0] r_v, n_v;
    t_st1 r_s1, n_s1;
    t_st2 r_s2, n_s2;
    t_st3 r_s3, n_s3;
    t_st4 r_s4, n_s4;
    t_st5 r_s5, n_s5;
    t_st6 r_s6, n_s6;
    logic signed [17:0] r_eased, n_eased;

    assign busy    = 1'b0;
    assign n_v     = {r_v[5:0], start & ~busy};
    assign o_valid = r_v[6];
    assign o_eased_value = r_eased;

    // ---------------- stage 1: clamp, decode, curve argument ----------------
    logic [16:0] w_r;
    logic [3:0]  w_idx;
    logic        w_lin;
    logic        w_low;
    logic [16:0] w_a;
    logic        w_out;
    logic        w_use_t;
    t_kind       w_kind;
    t_post       w_post;

    always_comb begin
        w_r   = (i_ratio > {1'b0, ONE_Q16[15:0]} + 17'd0 && i_ratio > ONE_Q16)
                ? ONE_Q16 : i_ratio;
        w_idx = 4'(i_func - 5'd1);
        w_lin = (i_func == FUNC_LINEAR) || (i_func > FUNC_LAST);
        w_low = w_r < HALF_Q16;
        w_a   = w_r;
        w_out = 1'b0;
        w_post = POST_NONE;
        case (w_idx[1:0])
            2'd0: begin
                w_out = 1'b0;
            end
            2'd1: begin
                w_out = 1'b1;
            end
            2'd2: begin
                // in-out: in curve on the lower half
                w_out  = ~w_low;
                w_a    = w_low ? {w_r[15:0], 1'b0} : 17'({w_r, 1'b0} - {1'b0, ONE_Q16});
                w_post = w_low ? POST_HALF : POST_HALF_UP;
            end
            default: begin
                // out-in: out curve on the lower half
                w_out  = w_low;
                w_a    = w_low ? {w_r[15:0], 1'b0} : 17'({w_r, 1'b0} - {1'b0, ONE_Q16});
                w_post = w_low ? POST_HALF : POST_HALF_UP;
            end
        endcase
        unique case (w_idx[3:2])
            2'd0:    w_kind = K_CUBIC;
            2'd1:    w_kind = K_BACK;
            2'd2:    w_kind = K_ELASTIC;
            default: w_kind = K_BOUNCE;
        endcase
        if (w_lin) begin
            w_kind = K_LIN;
            w_post = POST_NONE;
            w_a    = w_r;
        end
        // cubic and back work on t = a - 1 in the out form, elastic and bounce in the in form
        w_use_t = ((w_kind == K_ELASTIC) || (w_kind == K_BOUNCE)) ? ~w_out : w_out;

        n_s1.ctl.kind   = w_kind;
        n_s1.ctl.is_out = w_out;
        n_s1.ctl.post   = w_post;
        // elastic endpoints are exact: the value is the argument itself
        n_s1.ctl.ep     = (w_kind == K_ELASTIC) && ((w_a == 17'd0) || (w_a == ONE_Q16));
        n_s1.s          = w_use_t ? $signed({1'b0, w_a}) - $signed({1'b0, ONE_Q16})
                                  : $signed({1'b0, w_a});
        n_s1.b          = $signed({3'b000, w_a});
    end

    // ---------------- stage 2: squares, back product, phase, bounce segment ----------------
    logic signed [35:0] w_sq_full;
    logic signed [17:0] w_neg;
    logic [16:0]        w_mag;
    logic [19:0]        w_n;
    logic signed [21:0] w_s22;
    logic signed [21:0] w_pv;
    logic signed [20:0] w_e;

    always_comb begin
        w_sq_full = r_s1.s * r_s1.s;
        w_neg     = -r_s1.s;
        w_mag     = r_s1.s[17] ? w_neg[16:0] : r_s1.s[16:0];
        w_n       = ({3'b000, w_mag} << 3) + ({3'b000, w_mag} << 1);
        w_s22     = 22'(r_s1.s);
        // elastic phase (10 t - 0.75) / 3 turns, offset keeps it positive
        w_pv      = (w_s22 <<< 3) + (w_s22 <<< 1) + $signed({1'b0, PHASE_OFS});
        w_e       = $signed({1'b0, w_n}) + $signed({4'b0000, w_mag});

        n_s2.ctl  = r_s1.ctl;
        n_s2.s    = r_s1.s;
        n_s2.b    = r_s1.b;
        n_s2.sq   = w_sq_full[32:0];
        n_s2.m    = $signed(BACK_S1) * r_s1.s;
        n_s2.ej   = w_n[15 -: EXP_BITS];
        n_s2.eip  = w_n[19:16];
        n_s2.phm  = w_pv[20:0] * DIV3_RECIP;
        // bounce in elevenths: offsets 0, 6/11, 9/11, 21/22
        if (w_e < 21'sd262144) begin
            n_s2.u    = 20'(w_e);
            n_s2.badd = 16'd0;
        end else if (w_e < 21'sd524288) begin
            n_s2.u    = 20'(w_e - 21'sd393216);
            n_s2.badd = 16'd49152;
        end else if (w_e < 21'sd655360) begin
            n_s2.u    = 20'(w_e - 21'sd589824);
            n_s2.badd = 16'd61440;
        end else begin
            n_s2.u    = 20'(w_e - 21'sd688128);
            n_s2.badd = 16'd64512;
        end
    end

    // ---------------- stage 3: cube, back factors, table reads, bounce square ----------------
    logic signed [36:0]          w_mr;
    logic [15:0]                 w_ph;
    logic [SINE_BITS-1:0]        w_sidx;
    logic signed [39:0]          w_uu40;

    always_comb begin
        w_mr   = (r_s2.m + 37'sd32768) >>> 16;
        w_ph   = r_s2.phm[39:24];
        w_sidx = w_ph[15 -: SINE_BITS];
        w_uu40 = r_s2.u * r_s2.u;

        n_s3.ctl   = r_s2.ctl;
        n_s3.b     = r_s2.b;
        n_s3.c3    = $signed({1'b0, r_s2.sq}) * r_s2.s;
        n_s3.t2    = 17'((r_s2.sq + 33'd32768) >> 16);
        n_s3.inner = r_s2.ctl.is_out ? $signed(w_mr[19:0]) + $signed({3'b000, BACK_S})
                                     : $signed(w_mr[19:0]) - $signed({3'b000, BACK_S});
        n_s3.sn    = SINE_ROM[w_sidx];
        n_s3.ex    = EXP_ROM[r_s2.ej];
        n_s3.eip   = r_s2.eip;
        n_s3.uu    = w_uu40[36:0];
        n_s3.badd  = r_s2.badd;
    end

    // ---------------- stage 4: cubic and bounce done, back product, exp2 shift ----------------
    logic signed [51:0] w_c;
    logic [16:0]        w_bo;
    logic [4:0]         w_sh;
    logic [31:0]        w_ex32;

    always_comb begin
        w_c    = (r_s3.c3 + 52'sd2147483648) >>> 32;
        w_bo   = 17'((r_s3.uu + 37'd524288) >> 20) + {1'b0, r_s3.badd};
        w_sh   = 5'd14 + {1'b0, r_s3.eip};
        w_ex32 = {1'b0, r_s3.ex} + (32'd1 << (w_sh - 5'd1));

        n_s4.ctl = r_s3.ctl;
        n_s4.b   = r_s3.b;
        case (r_s3.ctl.kind)
            K_CUBIC: begin
                n_s4.b = $signed(w_c[19:0])
                         + (r_s3.ctl.is_out ? $signed({3'b000, ONE_Q16}) : 20'sd0);
            end
            K_BOUNCE: begin
                n_s4.b = r_s3.ctl.is_out ? $signed({3'b000, w_bo})
                                         : $signed({3'b000, ONE_Q16}) - $signed({3'b000, w_bo});
            end
            default: begin
                n_s4.b = r_s3.b;
            end
        endcase
        n_s4.bp = $signed({1'b0, r_s3.t2}) * r_s3.inner;
        n_s4.pw = 17'(w_ex32 >> w_sh);
        n_s4.sn = r_s3.sn;
    end

    // ---------------- stage 5: back done, elastic product ----------------
    logic signed [37:0] w_bk;

    always_comb begin
        w_bk     = (r_s4.bp + 38'sd32768) >>> 16;
        n_s5.ctl = r_s4.ctl;
        n_s5.b   = r_s4.b;
        if (r_s4.ctl.kind == K_BACK) begin
            n_s5.b = $signed(w_bk[19:0])
                     + (r_s4.ctl.is_out ? $signed({3'b000, ONE_Q16}) : 20'sd0);
        end
        n_s5.q = $signed({1'b0, r_s4.pw}) * r_s4.sn;
    end

    // ---------------- stage 6: elastic done ----------------
    logic signed [35:0] w_eq;

    always_comb begin
        w_eq     = (r_s5.q + 36'sd32768) >>> 16;
        n_s6.ctl = r_s5.ctl;
        n_s6.b   = r_s5.b;
        if ((r_s5.ctl.kind == K_ELASTIC) && !r_s5.ctl.ep) begin
            n_s6.b = r_s5.ctl.is_out ? $signed(w_eq[19:0]) + $signed({3'b000, ONE_Q16})
                                     : -$signed(w_eq[19:0]);
        end
    end

    // ---------------- stage 7: halving for the combined forms, saturation ----------------
    logic signed [20:0] w_b21;
    logic signed [20:0] w_h;
    logic signed [20:0] w_vv;

    always_comb begin
        w_b21 = 21'(r_s6.b);
        w_h   = (w_b21 + 21'sd1) >>> 1;
        case (r_s6.ctl.post)
            POST_HALF:    w_vv = w_h;
            POST_HALF_UP: w_vv = w_h + $signed({4'b0000, HALF_Q16});
            default:      w_vv = w_b21;
        endcase
        if (w_vv > 21'sd131071) begin
            n_eased = 18'sd131071;
        end else if (w_vv < -21'sd131072) begin
            n_eased = -18'sd131072;
        end else begin
            n_eased = w_vv[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    // datapath registers carry no reset, the valid bits qualify them
    always_ff @(posedge i_clk) begin
        r_s1    <= n_s1;
        r_s2    <= n_s2;
        r_s3    <= n_s3;
        r_s4    <= n_s4;
        r_s5    <= n_s5;
        r_s6    <= n_s6;
        r_eased <= n_eased;
    end

endmodule

>>> design/ecv_checker.sv
// port-level checker for the easing curve evaluator core, with its bind
// depends on ecv_pkg and on easing_curve_evaluator_core
module ecv_port_checker
    import ecv_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic [4:0]         i_func,
    input logic [16:0]        i_ratio,
    input logic               o_valid,
    input logic signed [17:0] o_eased_value
);

    // every accepted word gives a result on o_valid
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_valid)
        else $error("accepted word produced no result");

    // no result without a matching accepted word
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(start, 7) && !$past(busy, 7)))
        else $error("result without an accepted word");

    // linear curve returns the ratio unchanged
    a_linear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(i_func, 7) == FUNC_LINEAR && $past(i_ratio, 7) <= ONE_Q16)
        |-> (o_eased_value == $signed({1'b0, $past(i_ratio, 7)})))
        else $error("linear result differs from ratio");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !busy)
        else $error("busy raised");

endmodule

bind easing_curve_evaluator_core ecv_port_checker u_ecv_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_func        (i_func),
    .i_ratio       (i_ratio),
    .o_valid       (o_valid),
    .o_eased_value (o_eased_value)
);

>>> sim/ecv_checker.sv
`timescale 1ns / 1ps
// scoreboard for the easing curve evaluator: predicts each eased value and compares
// depends on ecv_pkg for depths and selector codes; builds its own sine and exp2 tables
module ecv_checker
    import ecv_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic [4:0]         i_func,
    input  logic [16:0]        i_ratio,
    input  logic               i_valid,
    input  logic signed [17:0] i_eased_value,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked
);

    typedef enum int {CRV_CUBIC, CRV_BACK, CRV_ELASTIC, CRV_BOUNCE} t_curve;
    typedef enum int {FORM_IN, FORM_OUT, FORM_INOUT, FORM_OUTIN} t_form;

    localparam longint Q16_ONE  = 65536;
    localparam longint Q30_ONE  = 64'sd1073741824;
    localparam longint BK_S     = 111515;
    localparam longint BK_S1    = 177051;
    localparam longint SAT_HIGH = 131071;
    localparam longint SAT_LOW  = -131072;

    longint                sine_q16 [SINE_TABLE_DEPTH];
    longint                exp2_q30 [EXP_TABLE_DEPTH];
    logic signed [17:0]    eased_queue [$];

    initial begin
        logic [63:0] f;
        logic [63:0] x;
        longint      xs;
        longint      term;
        longint      sum;
        logic        neg;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            f   = (64'(i) << 32) / SINE_TABLE_DEPTH;
            neg = 1'b0;
            if (f >= 64'h8000_0000) begin
                neg = 1'b1;
                f   = f - 64'h8000_0000;
            end
            if (f > 64'h4000_0000) f = 64'h8000_0000 - f;
            x    = (f * 64'd6746518852) >> 32;
            xs   = longint'(x);
            term = xs;
            sum  = xs;
            for (int k = 1; k <= 6; k++) begin
                term = (term * xs) / Q30_ONE;
                term = (term * xs) / Q30_ONE;
                term = -term / longint'((2 * k) * (2 * k + 1));
                sum  = sum + term;
            end
            if (sum < 0) sum = 0;
            sum         = (sum + 8192) >>> 14;
            sine_q16[i] = neg ? -sum : sum;
        end
        for (int j = 0; j < EXP_TABLE_DEPTH; j++) begin
            x    = (64'(j) << 32) / EXP_TABLE_DEPTH;
            xs   = longint'((x * 64'd744261118) >> 32);
            term = Q30_ONE;
            sum  = Q30_ONE;
            for (int k = 1; k <= 12; k++) begin
                term = -((term * xs) / Q30_ONE) / longint'(k);
                sum  = sum + term;
            end
            exp2_q30[j] = sum;
        end
    end

    // add half an lsb then floor
    function automatic longint round_shift(longint x, int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint pow2_neg(longint n);
        longint ip;
        longint idx;
        int     sh;
        ip  = n >>> 16;
        idx = ((n & 64'hFFFF) * EXP_TABLE_DEPTH) >>> 16;
        if (ip > 40) return 0;
        sh = 14 + int'(ip);
        return (exp2_q30[idx] + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    // phase (10t - 0.75)/3 turns, wrapped to one turn
    function automatic longint elastic_sin(longint t);
        longint ph;
        ph = ((10 * t + 737281) / 3) & 64'hFFFF;
        return sine_q16[(ph * SINE_TABLE_DEPTH) >>> 16];
    endfunction

    function automatic longint bounce_out(longint r);
        longint e;
        longint u;
        longint add;
        e = 11 * r;
        if (e < 4 * Q16_ONE) begin
            u = e;          add = 0;
        end else if (e < 8 * Q16_ONE) begin
            u = e - 393216; add = 49152;
        end else if (e < 10 * Q16_ONE) begin
            u = e - 589824; add = 61440;
        end else begin
            u = e - 688128; add = 64512;
        end
        return round_shift(u * u, 20) + add;
    endfunction

    function automatic longint curve_q16(t_curve kind, bit out_form, longint r);
        longint t;
        longint sq;
        t = r - Q16_ONE;
        case (kind)
            CRV_CUBIC: begin
                if (!out_form) return round_shift(r * r * r, 32);
                return round_shift(t * t * t, 32) + Q16_ONE;
            end
            CRV_BACK: begin
                if (!out_form) begin
                    sq = round_shift(r * r, 16);
                    return round_shift(sq * (round_shift(BK_S1 * r, 16) - BK_S), 16);
                end
                sq = round_shift(t * t, 16);
                return round_shift(sq * (round_shift(BK_S1 * t, 16) + BK_S), 16) + Q16_ONE;
            end
            CRV_ELASTIC: begin
                // endpoints are exact
                if (r == 0 || r == Q16_ONE) return r;
                if (!out_form)
                    return -round_shift(pow2_neg(10 * (Q16_ONE - r)) * elastic_sin(t), 16);
                return round_shift(pow2_neg(10 * r) * elastic_sin(r), 16) + Q16_ONE;
            end
            default: begin
                if (!out_form) return Q16_ONE - bounce_out(Q16_ONE - r);
                return bounce_out(r);
            end
        endcase
    endfunction

    function automatic logic signed [17:0] eased_expect(logic [4:0] func, logic [16:0] ratio);
        longint r;
        longint v;
        t_curve kind;
        t_form  form;
        bit     first_out;
        r = longint'(ratio);
        if (r > Q16_ONE) r = Q16_ONE;
        if (func == FUNC_LINEAR || func > FUNC_LAST) begin
            v = r;
        end else begin
            kind = t_curve'((int'(func) - 1) / 4);
            form = t_form'((int'(func) - 1) % 4);
            if (form == FORM_IN || form == FORM_OUT) begin
                v = curve_q16(kind, form == FORM_OUT, r);
            end else begin
                first_out = (form == FORM_OUTIN);
                if (r < Q16_ONE / 2)
                    v = round_shift(curve_q16(kind, first_out, 2 * r), 1);
                else
                    v = round_shift(curve_q16(kind, !first_out, 2 * r - Q16_ONE), 1)
                        + Q16_ONE / 2;
            end
        end
        if (v > SAT_HIGH) v = SAT_HIGH;
        if (v < SAT_LOW)  v = SAT_LOW;
        return 18'(v);
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    initial begin
        o_errors  = 0;
        o_checked = 0;
    end

    assign o_pending = eased_queue.size();

    always @(posedge i_clk) begin
        logic signed [17:0] want;
        if (i_rst_n) begin
            if (i_start && !i_busy) eased_queue.push_back(eased_expect(i_func, i_ratio));
            if (i_valid) begin
                if (eased_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected word %0d", i_eased_value));
                end else begin
                    want = eased_queue.pop_front();
                    o_checked++;
                    if (i_eased_value !== want)
                        report_mismatch($sformatf("eased_value %0d, want %0d",
                                                  i_eased_value, want));
                end
            end
        end
    end

endmodule

>>> sim/tb_easing_curve_evaluator_core.sv
`timescale 1ns / 1ps
// top of the easing curve evaluator testbench: clock, reset, stimulus and verdict
// depends on ecv_pkg, easing_curve_evaluator_core and ecv_checker
module tb_easing_curve_evaluator_core;
    import ecv_pkg::*;

    localparam int N_RANDOM   = 2000;
    localparam int TAIL_WAIT  = 20;   // a margin beyond the seven pipeline stages

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [4:0]         i_func = '0;
    logic [16:0]        i_ratio = '0;
    logic               o_valid;
    logic signed [17:0] o_eased_value;

    int errors;
    int pending;
    int checked;
    int words_sent;

    always #4 i_clk = ~i_clk;

    easing_curve_evaluator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_func        (i_func),
        .i_ratio       (i_ratio),
        .o_valid       (o_valid),
        .o_eased_value (o_eased_value)
    );

    ecv_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_func        (i_func),
        .i_ratio       (i_ratio),
        .i_valid       (o_valid),
        .i_eased_value (o_eased_value),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    // present one word from a falling edge and hold it until taken;
    // optional idle cycles first, start dropped only while idling
    task automatic send_word(input logic [4:0] f, input logic [16:0] r, input bit may_idle);
        while (may_idle && $urandom_range(99) < 16) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start   <= 1'b1;
        i_func  <= f;
        i_ratio <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // ratios mostly in range, some near the curve breakpoints, some above one
    function automatic logic [16:0] pick_ratio();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) return 17'($urandom_range(65536));
        if (sel < 85) return 17'(int'($urandom_range(4)) - 2 +
                                 32768 * int'($urandom_range(1, 1)) *
                                 int'($urandom_range(0, 2)) + 2);
        return 17'($urandom);
    endfunction

    initial begin
        logic [16:0] edge_ratio [7];
        logic [4:0]  f;
        edge_ratio = '{17'd0, 17'd65536, 17'd32767, 17'd32768, 17'd1, 17'd131071, 17'd65535};
        words_sent = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every curve, ratio extremes, unused selectors, elastic endpoints
        for (int i = 0; i <= int'(FUNC_LAST); i++)
            send_word(5'(i), edge_ratio[i % 7], 1'b0);
        send_word(5'd17, 17'd131071, 1'b0);
        send_word(5'd31, 17'd40000, 1'b0);
        for (int i = 9; i <= 12; i++) begin
            send_word(5'(i), 17'd0, 1'b0);
            send_word(5'(i), 17'd65536, 1'b0);
        end

        // random: mostly valid selectors, a long stretch with back-to-back words
        for (int n = 0; n < N_RANDOM; n++) begin
            f = ($urandom_range(9) == 0) ? 5'($urandom_range(17, 31))
                                         : 5'($urandom_range(16));
            send_word(f, pick_ratio(), !(n >= 800 && n < 1100));
        end
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("sent %0d words over all 17 curves and unused selectors, %0d results checked",
                 words_sent, checked);
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // safety net in case results stop coming
    initial begin
        #2ms;
        $display("timeout waiting for results");
        $display("Mismatches found");
        $finish;
    end

endmodule
